[rtl/mwhf_pkg.sv]
// Shared types, constants and small functions of the masked window hole filter.
package mwhf_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int HEIGHT_BITS_DEF = 32;

  localparam int WIN       = 7;
  localparam int FW_BITS   = 11;
  localparam int FH_BITS   = 13;
  localparam int ROW_BITS  = 13;
  localparam int NPIX_BITS = 24;
  localparam int LEAD_BITS = 13;
  localparam int SCAN_BITS = 25;
  localparam int WSUM_BITS = 11;
  localparam int CSUM_BITS = 18;
  localparam int WT_BITS   = 6;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [FW_BITS-1:0] FW_RESET  = 11'd1024;
  localparam logic [FH_BITS-1:0] FH_RESET  = 13'd4096;
  localparam logic               CEN_RESET = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOR_ENABLE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CTR_RD,
    ST_CTR_CHK,
    ST_SWEEP,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DSEL_H,
    DSEL_R,
    DSEL_G,
    DSEL_B
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     rd_ctr;
    logic     ctr_cap;
    logic     sweep_start;
    logic     sweep_step;
    logic     div_start;
    div_sel_t div_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic geom_busy;
    logic ctr_hole;
    logic sweep_last;
    logic wsum_zero;
    logic color_en;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic [WT_BITS-1:0] dist_weight(input logic [2:0] d);
    logic [WT_BITS-1:0] w;
    case (d)
      3'd0:    w = 6'd49;
      3'd1:    w = 6'd36;
      3'd2:    w = 6'd25;
      3'd3:    w = 6'd16;
      3'd4:    w = 6'd9;
      3'd5:    w = 6'd4;
      3'd6:    w = 6'd1;
      default: w = 6'd0;
    endcase
    return w;
  endfunction

  // Distance of a window tap from the centre tap.
  function automatic logic [2:0] abs_off(input logic [2:0] i);
    return (i >= 3'd3) ? (i - 3'd3) : (3'd3 - i);
  endfunction

  // Ring offset of window row i relative to the centre row slot: (i + 4) mod 7.
  function automatic logic [2:0] row_slot_off(input logic [2:0] i);
    return (i < 3'd3) ? (i + 3'd4) : (i - 3'd3);
  endfunction

endpackage

[rtl/masked_window_hole_filter_top.sv]
// Top level of the masked 7x7 window hole filter.
//
//  channel   direction  handshake            payload
//  in_       input      in_valid/in_ready    height_in, is_hole, red/green/blue_in, pad
//  out_      output     out_valid/out_ready  height_out, colors, was_filled,
//                                            no_neighbour, last_of_frame
//  cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item is taken one at a time. An item that yields no result is only taken; a
// non-hole centre is taken, its centre read and checked, and its result loaded. A hole
// centre adds a 49-tap sweep of the line store RAM (one read port, one tap per cycle),
// a drain and a divider load step, then, unless no tap added any weight, one divide for
// height and, with color enabled, three more for the colors. Reset is synchronous,
// active low; after reset or a geometry write the block holds in_ready low for one
// cycle. A result waiting on out_ready does not stop the next item from being taken;
// only the next result waits for the output register to free up.
module masked_window_hole_filter_top #(
  parameter int MAX_WIDTH   = mwhf_pkg::MAX_WIDTH_DEF,
  parameter int HEIGHT_BITS = mwhf_pkg::HEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mwhf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mwhf_pkg::FH_BITS-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [HEIGHT_BITS-1:0]     in_height_in,
  input  logic                              in_is_hole,
  input  logic [7:0]                        in_red_in,
  input  logic [7:0]                        in_green_in,
  input  logic [7:0]                        in_blue_in,
  input  logic                              in_pad,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [HEIGHT_BITS-1:0]     out_height_out,
  output logic [7:0]                        out_red_out,
  output logic [7:0]                        out_green_out,
  output logic [7:0]                        out_blue_out,
  output logic                              out_was_filled,
  output logic                              out_no_neighbour,
  output logic                              out_last_of_frame
);

  mwhf_pkg::cmd_t    cmd;
  mwhf_pkg::status_t status;

  // Configuration writes go straight into registers; always take them.
  assign cfg_ready = 1'b1;

  // Sequence each item: take, read centre, sweep window and divide for a hole, load result.
  mwhf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the line store, window sums, divider and result register.
  mwhf_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_height_in      (in_height_in),
    .in_is_hole        (in_is_hole),
    .in_red_in         (in_red_in),
    .in_green_in       (in_green_in),
    .in_blue_in        (in_blue_in),
    .in_pad            (in_pad),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_height_out    (out_height_out),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out),
    .out_was_filled    (out_was_filled),
    .out_no_neighbour  (out_no_neighbour),
    .out_last_of_frame (out_last_of_frame),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

[rtl/mwhf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mwhf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/mwhf_div.sv]
// Restoring divider, one quotient bit per cycle.
module mwhf_div #(
  parameter int DW = 43,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CNTW = $clog2(DW);

  logic            busy_r, done_r;
  logic [CNTW-1:0] cnt_r;
  logic [VW-1:0]   rem_r, dvs_r, rem_nxt;
  logic [DW-1:0]   quo_r, quo_nxt;
  logic [VW:0]     trial;

  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = VW'(trial - {1'b0, dvs_r});
      quo_nxt = {quo_r[DW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dvs_r <= divisor;
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

[rtl/mwhf_datapath.sv]
// Datapath: config registers, counters, line store, window sums, divider, result register.
module mwhf_datapath #(
  parameter int MAX_WIDTH   = mwhf_pkg::MAX_WIDTH_DEF,
  parameter int HEIGHT_BITS = mwhf_pkg::HEIGHT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic [mwhf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mwhf_pkg::FH_BITS-1:0]          cfg_data,
  input  logic signed [HEIGHT_BITS-1:0]         in_height_in,
  input  logic                                  in_is_hole,
  input  logic [7:0]                            in_red_in,
  input  logic [7:0]                            in_green_in,
  input  logic [7:0]                            in_blue_in,
  input  logic                                  in_pad,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [HEIGHT_BITS-1:0]         out_height_out,
  output logic [7:0]                            out_red_out,
  output logic [7:0]                            out_green_out,
  output logic [7:0]                            out_blue_out,
  output logic                                  out_was_filled,
  output logic                                  out_no_neighbour,
  output logic                                  out_last_of_frame,
  input  mwhf_pkg::cmd_t                        cmd,
  output mwhf_pkg::status_t                     status
);

  localparam int HB     = HEIGHT_BITS;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int DEPTH  = mwhf_pkg::WIN * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int PW     = HB + 25;
  localparam int HSUMW  = HB + 10;
  localparam int DW     = HB + 11;
  localparam int XW     = (CW + 1 > mwhf_pkg::FW_BITS) ? CW + 1 : mwhf_pkg::FW_BITS;
  localparam int HOLE_BIT = HB + 24;
  localparam logic [2:0] LAST_TAP  = 3'(mwhf_pkg::WIN - 1);
  localparam logic [2:0] LAST_SLOT = 3'(mwhf_pkg::WIN - 1);

  // configuration
  logic [mwhf_pkg::FW_BITS-1:0]   fw_r, effw_c, effw_r;
  logic [mwhf_pkg::FH_BITS-1:0]   fh_r, effh_c, effh_r;
  logic                           cen_r, geom_busy_r, geom_wr;
  logic [mwhf_pkg::NPIX_BITS-1:0] npix_c, npix_r;
  logic [mwhf_pkg::LEAD_BITS-1:0] lead_c, lead_r;
  logic [mwhf_pkg::SCAN_BITS-1:0] total_c, total_r;

  assign geom_wr = cfg_valid && (cfg_index == mwhf_pkg::REG_FRAME_WIDTH ||
                                 cfg_index == mwhf_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= mwhf_pkg::FW_RESET;
      fh_r        <= mwhf_pkg::FH_RESET;
      cen_r       <= mwhf_pkg::CEN_RESET;
      geom_busy_r <= 1'b1;
    end else begin
      geom_busy_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          mwhf_pkg::REG_FRAME_WIDTH: begin
            fw_r        <= cfg_data[mwhf_pkg::FW_BITS-1:0];
            geom_busy_r <= 1'b1;
          end
          mwhf_pkg::REG_FRAME_HEIGHT: begin
            fh_r        <= cfg_data;
            geom_busy_r <= 1'b1;
          end
          mwhf_pkg::REG_COLOR_ENABLE: cen_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (fw_r == '0) begin
      effw_c = mwhf_pkg::FW_BITS'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      effw_c = mwhf_pkg::FW_BITS'(MAX_WIDTH);
    end else begin
      effw_c = fw_r;
    end
    effh_c  = (fh_r == '0) ? mwhf_pkg::FH_BITS'(1) : fh_r;
    npix_c  = {13'd0, effw_c} * {11'd0, effh_c};
    lead_c  = {1'b0, effw_c, 1'b0} + {2'b0, effw_c} + 13'd3;
    total_c = {1'b0, npix_c} + {12'd0, lead_c};
  end

  always_ff @(posedge clk) begin
    effw_r  <= effw_c;
    effh_r  <= effh_c;
    npix_r  <= npix_c;
    lead_r  <= lead_c;
    total_r <= total_c;
  end

  // scan and write position, centre position
  logic [mwhf_pkg::SCAN_BITS-1:0] scan_r, scan_inc;
  logic [CW-1:0]                  wcol_r, ccol_r;
  logic [2:0]                     wslot_r, cslot_r;
  logic [mwhf_pkg::ROW_BITS-1:0]  crow_r;
  logic                           frame_end_r;
  logic                           drop_c, emit_c, wrap_c, wr_c, wcol_end, ccol_end;

  assign scan_inc = scan_r + 1'b1;
  assign drop_c   = (scan_r == '0) && in_pad;
  assign emit_c   = !drop_c && ({12'd0, lead_r} <= scan_r);
  assign wrap_c   = scan_inc >= total_r;
  assign wr_c     = cmd.accept && !drop_c && (scan_r < {1'b0, npix_r});
  assign wcol_end = (XW'(wcol_r) + 1'b1) == XW'(effw_r);
  assign ccol_end = (XW'(ccol_r) + 1'b1) == XW'(effw_r);

  always_ff @(posedge clk) begin
    if (!rst_n || geom_wr) begin
      scan_r      <= '0;
      wcol_r      <= '0;
      wslot_r     <= '0;
      ccol_r      <= '0;
      crow_r      <= '0;
      cslot_r     <= '0;
      frame_end_r <= 1'b0;
    end else begin
      if (cmd.accept && !drop_c) begin
        scan_r      <= wrap_c ? '0 : scan_inc;
        frame_end_r <= wrap_c;
        if (wrap_c) begin
          wcol_r  <= '0;
          wslot_r <= '0;
        end else if (wr_c) begin
          if (wcol_end) begin
            wcol_r  <= '0;
            wslot_r <= (wslot_r == LAST_SLOT) ? 3'd0 : wslot_r + 3'd1;
          end else begin
            wcol_r <= wcol_r + 1'b1;
          end
        end
      end
      if (cmd.out_load) begin
        if (frame_end_r) begin
          ccol_r  <= '0;
          crow_r  <= '0;
          cslot_r <= '0;
        end else if (ccol_end) begin
          ccol_r  <= '0;
          crow_r  <= crow_r + 1'b1;
          cslot_r <= (cslot_r == LAST_SLOT) ? 3'd0 : cslot_r + 3'd1;
        end else begin
          ccol_r <= ccol_r + 1'b1;
        end
      end
    end
  end

  // window sweep addressing
  logic [2:0]                    di_r, dj_r, roff, rslot;
  logic [3:0]                    rsum;
  logic [mwhf_pkg::FH_BITS:0]    tr;
  logic [XW-1:0]                 tc;
  logic                          ok_row, ok_col;
  logic [CW-1:0]                 tap_col;
  logic [AW-1:0]                 ctr_addr, tap_addr, raddr, waddr;
  logic [mwhf_pkg::WT_BITS-1:0]  wt_c, wt_r;
  logic                          acc_vld_r;

  always_comb begin
    roff    = mwhf_pkg::row_slot_off(di_r);
    rsum    = {1'b0, cslot_r} + {1'b0, roff};
    rslot   = (rsum >= 4'd7) ? 3'(rsum - 4'd7) : rsum[2:0];
    tr      = {1'b0, crow_r} + (mwhf_pkg::FH_BITS + 1)'(di_r);
    ok_row  = (tr >= 14'd3) && ((tr - 14'd3) < {1'b0, effh_r});
    tc      = XW'(ccol_r) + XW'(dj_r);
    ok_col  = (tc >= XW'(3)) && ((tc - XW'(3)) < XW'(effw_r));
    tap_col = CW'(tc - XW'(3));
    tap_addr = AW'(int'(rslot) * MAX_WIDTH + int'(tap_col));
    ctr_addr = AW'(int'(cslot_r) * MAX_WIDTH + int'(ccol_r));
    waddr    = AW'(int'(wslot_r) * MAX_WIDTH + int'(wcol_r));
    raddr    = cmd.rd_ctr ? ctr_addr : tap_addr;
    wt_c     = mwhf_pkg::dist_weight(mwhf_pkg::abs_off(di_r) + mwhf_pkg::abs_off(dj_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= cmd.sweep_step && ok_row && ok_col;
    end
  end

  always_ff @(posedge clk) begin
    wt_r <= wt_c;
    if (cmd.sweep_start) begin
      di_r <= '0;
      dj_r <= '0;
    end else if (cmd.sweep_step) begin
      if (dj_r == LAST_TAP) begin
        dj_r <= '0;
        di_r <= di_r + 3'd1;
      end else begin
        dj_r <= dj_r + 3'd1;
      end
    end
  end

  // line store
  logic [PW-1:0] wdata, rdata, ctr_pix_r;

  assign wdata = {in_is_hole, in_blue_in, in_green_in, in_red_in, in_height_in};

  mwhf_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_c),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_ctr || cmd.sweep_step),
    .raddr (raddr),
    .rdata (rdata)
  );

  // weighted sums
  logic signed [HB-1:0]            nb_h;
  logic signed [HB+6:0]            hprod;
  logic signed [HSUMW-1:0]         hsum_r;
  logic [mwhf_pkg::WSUM_BITS-1:0]  wsum_r;
  logic [mwhf_pkg::CSUM_BITS-1:0]  rsum_r, gsum_r, bsum_r;

  assign nb_h  = $signed(rdata[HB-1:0]);
  assign hprod = $signed({1'b0, wt_r}) * nb_h;

  always_ff @(posedge clk) begin
    if (cmd.ctr_cap) begin
      ctr_pix_r <= rdata;
    end
    if (cmd.sweep_start) begin
      wsum_r <= '0;
      hsum_r <= '0;
      rsum_r <= '0;
      gsum_r <= '0;
      bsum_r <= '0;
    end else if (acc_vld_r && !rdata[HOLE_BIT]) begin
      wsum_r <= wsum_r + mwhf_pkg::WSUM_BITS'(wt_r);
      hsum_r <= hsum_r + HSUMW'(hprod);
      rsum_r <= rsum_r + mwhf_pkg::CSUM_BITS'(wt_r) * mwhf_pkg::CSUM_BITS'(rdata[HB+7:HB]);
      gsum_r <= gsum_r + mwhf_pkg::CSUM_BITS'(wt_r) * mwhf_pkg::CSUM_BITS'(rdata[HB+15:HB+8]);
      bsum_r <= bsum_r + mwhf_pkg::CSUM_BITS'(wt_r) * mwhf_pkg::CSUM_BITS'(rdata[HB+23:HB+16]);
    end
  end

  // division
  logic                            hneg;
  logic [HSUMW-1:0]                hmag;
  logic [DW-1:0]                   dividend, quotient;
  logic [mwhf_pkg::WSUM_BITS-1:0]  divisor;
  logic                            div_done;
  mwhf_pkg::div_sel_t              dsel_r;
  logic [HB-1:0]                   hq_r;
  logic [7:0]                      rq_r, gq_r, bq_r;

  assign hneg = hsum_r[HSUMW-1];
  assign hmag = hneg ? (~hsum_r + 1'b1) : hsum_r;

  always_comb begin
    case (cmd.div_sel)
      mwhf_pkg::DSEL_H: begin
        dividend = {hmag, 1'b0} + DW'(wsum_r);
        divisor  = {wsum_r[mwhf_pkg::WSUM_BITS-2:0], 1'b0};
      end
      mwhf_pkg::DSEL_R: begin
        dividend = DW'(rsum_r);
        divisor  = wsum_r;
      end
      mwhf_pkg::DSEL_G: begin
        dividend = DW'(gsum_r);
        divisor  = wsum_r;
      end
      default: begin
        dividend = DW'(bsum_r);
        divisor  = wsum_r;
      end
    endcase
  end

  mwhf_div #(
    .DW (DW),
    .VW (mwhf_pkg::WSUM_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dsel_r <= cmd.div_sel;
    end
    if (div_done) begin
      case (dsel_r)
        mwhf_pkg::DSEL_H: hq_r <= quotient[HB-1:0];
        mwhf_pkg::DSEL_R: rq_r <= quotient[7:0];
        mwhf_pkg::DSEL_G: gq_r <= quotient[7:0];
        default:          bq_r <= quotient[7:0];
      endcase
    end
  end

  // result register
  logic                 ctr_hole, fill;
  logic                 out_valid_r, filled_r, none_r, last_r;
  logic signed [HB-1:0] hout_r;
  logic [7:0]           rout_r, gout_r, bout_r;

  assign ctr_hole = ctr_pix_r[HOLE_BIT];
  assign fill     = ctr_hole && (wsum_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hout_r   <= fill ? (hneg ? $signed(~hq_r + 1'b1) : $signed(hq_r))
                       : $signed(ctr_pix_r[HB-1:0]);
      rout_r   <= (fill && cen_r) ? rq_r : ctr_pix_r[HB+7:HB];
      gout_r   <= (fill && cen_r) ? gq_r : ctr_pix_r[HB+15:HB+8];
      bout_r   <= (fill && cen_r) ? bq_r : ctr_pix_r[HB+23:HB+16];
      filled_r <= fill;
      none_r   <= ctr_hole && !fill;
      last_r   <= (({1'b0, crow_r} + 14'd1) == {1'b0, effh_r}) && ccol_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_height_out    = hout_r;
  assign out_red_out       = rout_r;
  assign out_green_out     = gout_r;
  assign out_blue_out      = bout_r;
  assign out_was_filled    = filled_r;
  assign out_no_neighbour  = none_r;
  assign out_last_of_frame = last_r;

  always_comb begin
    status.emit       = emit_c;
    status.geom_busy  = geom_busy_r;
    status.ctr_hole   = rdata[HOLE_BIT];
    status.sweep_last = (di_r == LAST_TAP) && (dj_r == LAST_TAP);
    status.wsum_zero  = (wsum_r == '0);
    status.color_en   = cen_r;
    status.div_done   = div_done;
    status.out_free   = !out_valid_r || out_ready;
  end

endmodule

[rtl/mwhf_ctrl.sv]
// Controller state machine of the hole filter.
module mwhf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mwhf_pkg::status_t status,
  output mwhf_pkg::cmd_t    cmd
);

  mwhf_pkg::state_t   state_r, state_nxt;
  mwhf_pkg::div_sel_t sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mwhf_pkg::ST_IDLE;
      sel_r   <= mwhf_pkg::DSEL_H;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.div_sel = sel_r;
    in_ready    = 1'b0;
    case (state_r)
      mwhf_pkg::ST_IDLE: begin
        in_ready   = !status.geom_busy;
        cmd.accept = in_valid && !status.geom_busy;
        if (cmd.accept && status.emit) begin
          state_nxt = mwhf_pkg::ST_CTR_RD;
        end
      end
      mwhf_pkg::ST_CTR_RD: begin
        cmd.rd_ctr = 1'b1;
        state_nxt  = mwhf_pkg::ST_CTR_CHK;
      end
      mwhf_pkg::ST_CTR_CHK: begin
        cmd.ctr_cap = 1'b1;
        if (status.ctr_hole) begin
          cmd.sweep_start = 1'b1;
          state_nxt       = mwhf_pkg::ST_SWEEP;
        end else begin
          state_nxt = mwhf_pkg::ST_OUT;
        end
      end
      mwhf_pkg::ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_nxt = mwhf_pkg::ST_DRAIN;
        end
      end
      mwhf_pkg::ST_DRAIN: begin
        state_nxt = mwhf_pkg::ST_DIV_LOAD;
      end
      mwhf_pkg::ST_DIV_LOAD: begin
        if (status.wsum_zero) begin
          state_nxt = mwhf_pkg::ST_OUT;
        end else begin
          sel_nxt       = mwhf_pkg::DSEL_H;
          cmd.div_sel   = mwhf_pkg::DSEL_H;
          cmd.div_start = 1'b1;
          state_nxt     = mwhf_pkg::ST_DIV_RUN;
        end
      end
      mwhf_pkg::ST_DIV_RUN: begin
        if (status.div_done) begin
          if (sel_r == mwhf_pkg::DSEL_B ||
              (sel_r == mwhf_pkg::DSEL_H && !status.color_en)) begin
            state_nxt = mwhf_pkg::ST_OUT;
          end else begin
            sel_nxt       = mwhf_pkg::div_sel_t'(sel_r + 2'd1);
            cmd.div_sel   = sel_nxt;
            cmd.div_start = 1'b1;
          end
        end
      end
      mwhf_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = mwhf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mwhf_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_div_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state_r == mwhf_pkg::ST_DIV_RUN)
    else $error("divider started outside the division phase");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> state_r == mwhf_pkg::ST_DIV_RUN)
    else $error("divider finished while nobody waits for it");

  a_sweep_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_start |=> (state_r == mwhf_pkg::ST_SWEEP && !status.sweep_last))
    else $error("window sweep did not restart at the first tap");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !status.emit) |=> state_r == mwhf_pkg::ST_IDLE)
    else $error("item without a result left the idle state");
`endif

endmodule
